// ===== rtl/itc_pkg.sv =====
// Shared types and constants for the integer to ASCII digit converter.
// No dependencies.
package itc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_VALUE_W     = 32;

  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A_LC  = 8'h61;

  localparam logic [3:0] DIGIT_TEN = 4'd10;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [1:0]            mode;
  } itc_req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } itc_rsp_t;

  typedef struct packed {
    logic neg;
    logic hex;
  } itc_ctl_t;

endpackage

// ===== rtl/integer_to_ascii_digits.sv =====
// Decimal runs the shift-add loop over all VALUE_BITS bits, then scans the BCD digit positions
//   (10 at VALUE_BITS = 32), emitting a sign first if negative; hex skips the shift-add.
// The engine takes a new request only after emitting the last character of the previous one;
//   character output stalls while out_ready holds back a pending character.
// A two-entry queue takes requests while the engine works. Reset clears the state machine,
// the output valid and the queue pointers and count. Top level; depends on itc_pkg, itc_front, itc_queue, itc_back.
module integer_to_ascii_digits #(
  parameter int VALUE_BITS = itc_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itc_pkg::itc_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output itc_pkg::itc_rsp_t out_data
);
  import itc_pkg::*;

  logic [VALUE_BITS-1:0] f_mag;
  itc_ctl_t              f_ctl;
  logic                  q_full;
  logic                  q_avail;
  logic                  q_pop;
  logic [VALUE_BITS-1:0] q_mag;
  itc_ctl_t              q_ctl;

  assign in_ready = !q_full;

  itc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_data (in_data),
    .mag     (f_mag),
    .ctl     (f_ctl)
  );

  itc_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && !q_full),
    .push_mag (f_mag),
    .push_ctl (f_ctl),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_mag  (q_mag),
    .pop_ctl  (q_ctl)
  );

  itc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (q_avail),
    .q_mag     (q_mag),
    .q_ctl     (q_ctl),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/itc_front.sv =====
// Front end: truncates or zero-extends the incoming value to VALUE_BITS, classifies the mode and forms the magnitude.
// Depends on itc_pkg.
module itc_front #(
  parameter int VALUE_BITS = 32
) (
  input  itc_pkg::itc_req_t      in_data,
  output logic [VALUE_BITS-1:0]  mag,
  output itc_pkg::itc_ctl_t      ctl
);
  import itc_pkg::*;

  logic [VALUE_BITS-1:0] v;

  generate
    if (VALUE_BITS <= IN_VALUE_W) begin : g_narrow
      assign v = in_data.value[VALUE_BITS-1:0];
    end else begin : g_wide
      assign v = VALUE_BITS'(in_data.value);
    end
  endgenerate

  always_comb begin
    ctl.neg = (in_data.mode == MODE_SDEC) && v[VALUE_BITS-1];
    ctl.hex = (in_data.mode == MODE_HEX);
    mag     = ctl.neg ? (~v + VALUE_BITS'(1)) : v;
  end

endmodule

// ===== rtl/itc_queue.sv =====
// Two-entry request queue between the front end and the conversion engine.
// Depends on itc_pkg.
module itc_queue #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [VALUE_BITS-1:0] push_mag,
  input  itc_pkg::itc_ctl_t     push_ctl,
  output logic                  full,
  input  logic                  pop,
  output logic                  avail,
  output logic [VALUE_BITS-1:0] pop_mag,
  output itc_pkg::itc_ctl_t     pop_ctl
);
  import itc_pkg::*;

  logic [VALUE_BITS-1:0] mag_r [2];
  itc_ctl_t              ctl_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign avail   = (cnt_r != 2'd0);
  assign pop_mag = mag_r[rd_ptr_r];
  assign pop_ctl = ctl_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mag_r[wr_ptr_r] <= push_mag;
      ctl_r[wr_ptr_r] <= push_ctl;
    end
  end

endmodule

// ===== rtl/itc_back.sv =====
// Conversion engine: shift-add binary to BCD for decimal (hex skips it), then serial character output.
// Depends on itc_pkg.
module itc_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_avail,
  input  logic [VALUE_BITS-1:0] q_mag,
  input  itc_pkg::itc_ctl_t     q_ctl,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output itc_pkg::itc_rsp_t     out_data
);
  import itc_pkg::*;

  localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CW     = $clog2(VALUE_BITS);
  localparam int DIG_CW     = $clog2(NUM_DIGITS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic                  neg_r, neg_nxt;
  logic                  seen_r, seen_nxt;
  logic [BIT_CW-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CW-1:0]     dig_cnt_r, dig_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  itc_rsp_t              out_data_r, out_data_nxt;

  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            dig;
  logic [7:0]            dig_char;
  logic                  out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_avail;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                   : bcd_r[4*i +: 4];
    end
  end

  assign dig      = bcd_r[BCD_W-1 -: 4];
  assign dig_char = (dig < DIGIT_TEN) ? CHAR_ZERO + 8'(dig)
                                      : CHAR_A_LC + 8'(dig - DIGIT_TEN);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    seen_nxt      = seen_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_avail) begin
          mag_nxt     = q_mag;
          bcd_nxt     = q_ctl.hex ? BCD_W'(q_mag) : '0;
          neg_nxt     = q_ctl.neg;
          seen_nxt    = 1'b0;
          bit_cnt_nxt = BIT_CW'(VALUE_BITS - 1);
          dig_cnt_nxt = DIG_CW'(NUM_DIGITS - 1);
          state_nxt   = q_ctl.hex ? S_EMIT : S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BIT_CW'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (neg_r) begin
            neg_nxt                = 1'b0;
            out_valid_nxt          = 1'b1;
            out_data_nxt.char_code = CHAR_MINUS;
            out_data_nxt.last      = 1'b0;
          end else if (dig == 4'd0 && !seen_r && dig_cnt_r != '0) begin
            bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
            dig_cnt_nxt = dig_cnt_r - DIG_CW'(1);
          end else begin
            seen_nxt               = 1'b1;
            out_valid_nxt          = 1'b1;
            out_data_nxt.char_code = dig_char;
            out_data_nxt.last      = (dig_cnt_r == '0);
            bcd_nxt                = {bcd_r[BCD_W-5:0], 4'd0};
            dig_cnt_nxt            = dig_cnt_r - DIG_CW'(1);
            if (dig_cnt_r == '0) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    seen_r     <= seen_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/itc_checker.sv =====
// Port-level checks for the integer to ASCII digit converter, bound to the top level.
// Depends on itc_pkg and integer_to_ascii_digits.
module itc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input itc_pkg::itc_rsp_t out_data
);
  import itc_pkg::*;

  logic is_minus;
  logic is_dec;
  logic is_hex;

  assign is_minus = (out_data.char_code == CHAR_MINUS);
  assign is_dec   = (out_data.char_code >= CHAR_ZERO) &&
                    (out_data.char_code <= CHAR_ZERO + 8'd9);
  assign is_hex   = (out_data.char_code >= CHAR_A_LC) &&
                    (out_data.char_code <= CHAR_A_LC + 8'd5);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("response valid or request blocked right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled response changed");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_minus || is_dec || is_hex)
    else $error("illegal character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_minus |-> !out_data.last)
    else $error("sign marked as last character");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && is_minus |=> !(out_valid && is_minus))
    else $error("sign followed by another sign");

endmodule

bind integer_to_ascii_digits itc_checker u_itc_checker (.*);
